// ===== src/lbt_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants for the lbt transmit queue scheduler
// no dependencies
package lbt_pkg;

	localparam int QUEUE_SLOTS      = 4;
	localparam int MAX_PACKET_BYTES = 255;
	localparam int SLOT_SPAN        = 256;
	localparam int SLOT_W           = $clog2(QUEUE_SLOTS);
	localparam int CNT_W            = $clog2(QUEUE_SLOTS + 1);
	localparam int OFFS_W           = $clog2(SLOT_SPAN);
	localparam int STORE_DEPTH      = QUEUE_SLOTS * SLOT_SPAN;
	localparam int ADDR_W           = $clog2(STORE_DEPTH);

	// payload field widths
	localparam int MODE_W   = 3;
	localparam int BYTE_W   = 8;
	localparam int SCAN_W   = 2;
	localparam int STATUS_W = 2;
	localparam int TIME_W   = 32;
	localparam int RSLOT_W  = 2;
	localparam int ACTION_W = 4;
	localparam int TXSLOT_W = 2;
	localparam int RETRY_W  = 4;
	localparam int DEPTH_W  = 3;
	localparam int SETTLE_W = 16;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] CFG_BUSY_RETRY_LIMIT = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_TIME_MS   = 1'd1;

	localparam logic [RETRY_W-1:0]  RETRY_RESET  = 4'd3;
	localparam logic [SETTLE_W-1:0] SETTLE_RESET = 16'd10;
	localparam logic [RETRY_W-1:0]  RETRY_MAX    = 4'd15;

	typedef enum logic [MODE_W-1:0] {
		MODE_INIT_DONE = 3'd0,
		MODE_ENQUEUE   = 3'd1,
		MODE_POLL      = 3'd2,
		MODE_RX_IRQ    = 3'd3,
		MODE_TX_IRQ    = 3'd4,
		MODE_READ_BYTE = 3'd5
	} mode_t;

	typedef enum logic [SCAN_W-1:0] {
		SCAN_FREE = 2'd0,
		SCAN_BUSY = 2'd1
	} scan_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK  = 2'd0,
		STAT_CRC = 2'd1
	} status_t;

	typedef enum logic [ACTION_W-1:0] {
		ACT_NONE       = 4'd0,
		ACT_QUEUED     = 4'd1,
		ACT_REJECTED   = 4'd2,
		ACT_RX_DELIVER = 4'd3,
		ACT_CRC_ERR    = 4'd4,
		ACT_READ_ERR   = 4'd5,
		ACT_TX_DONE    = 4'd6,
		ACT_RX_RESUMED = 4'd7,
		ACT_TX_START   = 4'd8,
		ACT_TX_FAIL    = 4'd9,
		ACT_BUSY       = 4'd10,
		ACT_SCAN_ERR   = 4'd11,
		ACT_BYTE       = 4'd12
	} action_t;

	typedef enum logic [2:0] {
		LS_UNINIT = 3'd0,
		LS_IDLE   = 3'd1,
		LS_TX     = 3'd2,
		LS_RXED   = 3'd3,
		LS_SENT   = 3'd4,
		LS_SETTLE = 3'd5
	} link_state_t;

endpackage

// ===== src/lbt_in_if.sv =====
`timescale 1ns / 1ps
// input channel of the lbt scheduler: valid/ready plus one item's fields
// depends on lbt_pkg
interface lbt_in_if;
	logic                          valid;
	logic                          ready;
	logic [lbt_pkg::MODE_W-1:0]    mode;
	logic [lbt_pkg::BYTE_W-1:0]    data_byte;
	logic                          last_byte;
	logic [lbt_pkg::SCAN_W-1:0]    scan_result;
	logic [lbt_pkg::STATUS_W-1:0]  radio_status;
	logic [lbt_pkg::TIME_W-1:0]    now_ms;
	logic [lbt_pkg::RSLOT_W-1:0]   read_slot;
	logic [lbt_pkg::BYTE_W-1:0]    read_offset;

	modport source (
		output valid, mode, data_byte, last_byte, scan_result, radio_status, now_ms,
			read_slot, read_offset,
		input  ready
	);
	modport sink (
		input  valid, mode, data_byte, last_byte, scan_result, radio_status, now_ms,
			read_slot, read_offset,
		output ready
	);
endinterface

// ===== src/lbt_out_if.sv =====
`timescale 1ns / 1ps
// result channel of the lbt scheduler: valid/ready plus one result's fields
// depends on lbt_pkg
interface lbt_out_if;
	logic                          valid;
	logic                          ready;
	logic [lbt_pkg::ACTION_W-1:0]  action;
	logic [lbt_pkg::TXSLOT_W-1:0]  tx_slot;
	logic [lbt_pkg::BYTE_W-1:0]    tx_length;
	logic [lbt_pkg::BYTE_W-1:0]    read_data;
	logic [lbt_pkg::RETRY_W-1:0]   busy_count;
	logic [lbt_pkg::DEPTH_W-1:0]   queue_depth;

	modport source (
		output valid, action, tx_slot, tx_length, read_data, busy_count, queue_depth,
		input  ready
	);
	modport sink (
		input  valid, action, tx_slot, tx_length, read_data, busy_count, queue_depth,
		output ready
	);
endinterface

// ===== src/lbt_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write, single-port-read ram with registered read data
// no dependencies
module lbt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

// ===== src/lbt_tx_queue_scheduler_core.sv =====
`timescale 1ns / 1ps
// top level of the listen-before-talk transmit queue scheduler
// depends on lbt_pkg, lbt_in_if, lbt_out_if and lbt_ram
//
// usage:
//   in_ch carries one transaction per item: init done, enqueue byte, poll,
//   rx irq, tx irq or read byte. out_ch returns exactly one result transaction
//   for every input transaction, in order.
//   cfg_we/cfg_index/cfg_data write busy_retry_limit (index 0) and
//   settle_time_ms (index 1); write them only while no item is in flight.
// timing:
//   an item is taken on the edge where in_ch.valid and in_ch.ready are high;
//   its result is shown in the next cycle from a single output stage.
//   one item per cycle sustained while no result is held by out_ch.ready; the
//   packet store ram has a registered read, which only read byte items use.
//   all state updates for an item happen on its accept edge, so a byte
//   written by an enqueue is visible to a read byte in the very next cycle.
// reset:
//   arst_n clears the link state, ring pointers, counters and config to their
//   reset values at once; the packet store and slot lengths are not cleared
//   and there is no clearing pass.
// stall:
//   while a result is pending and out_ch.ready is low the result holds and
//   in_ch.ready drops, so no new item enters and the ram read data stays put.
module lbt_tx_queue_scheduler_core (
	input  logic                              clk,
	input  logic                              arst_n,
	lbt_in_if.sink                            in_ch,
	lbt_out_if.source                         out_ch,
	input  logic                              cfg_we,
	input  logic [lbt_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [lbt_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lbt_pkg::*;

	// configuration registers
	logic [RETRY_W-1:0]  retry_limit_q;
	logic [SETTLE_W-1:0] settle_time_q;

	// link and ring state
	link_state_t         link_q, link_d;
	logic [SLOT_W-1:0]   head_q, head_d;
	logic [SLOT_W-1:0]   tail_q, tail_d;
	logic [CNT_W-1:0]    count_q, count_d;
	logic [OFFS_W-1:0]   fill_q, fill_d;
	logic                ovf_q, ovf_d;
	logic [RETRY_W-1:0]  busy_q, busy_d;
	logic [TIME_W-1:0]   deadline_q, deadline_d;
	logic [BYTE_W-1:0]   slot_len_q [QUEUE_SLOTS];
	logic                len_we;

	// output stage
	logic                valid_s1;
	action_t             act_s1;
	logic [TXSLOT_W-1:0] txs_s1;
	logic [BYTE_W-1:0]   txl_s1;
	logic                rdsel_s1;
	logic [RETRY_W-1:0]  busy_s1;
	logic [DEPTH_W-1:0]  depth_s1;

	// per-item decode
	logic                accept;
	mode_t               mode;
	logic                store_ok;
	logic [OFFS_W-1:0]   fill_inc;
	logic                ovf_inc;
	logic [RETRY_W-1:0]  busy_inc;
	logic                ring_nonempty;
	logic                launch;
	logic                launch_ok;
	logic                settle_done;
	logic                read_in_range;
	action_t             act_d;
	logic [TXSLOT_W-1:0] txs_d;
	logic [BYTE_W-1:0]   txl_d;

	logic                ram_we;
	logic                ram_re;
	logic [ADDR_W-1:0]   ram_waddr;
	logic [ADDR_W-1:0]   ram_raddr;
	logic [BYTE_W-1:0]   ram_rdata;

	// handshake: take a new item whenever the output stage is free or draining
	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign accept      = in_ch.valid && in_ch.ready;
	assign mode        = mode_t'(in_ch.mode);

	// byte assembly into the tail slot
	assign store_ok = (count_q < CNT_W'(QUEUE_SLOTS)) &&
		(fill_q < OFFS_W'(MAX_PACKET_BYTES)) && !ovf_q;
	assign fill_inc = store_ok ? fill_q + 1'b1 : fill_q;
	assign ovf_inc  = ovf_q || !store_ok;

	// listen-before-talk decision for a poll in idle with packets waiting
	assign busy_inc      = (busy_q < RETRY_MAX) ? busy_q + 1'b1 : busy_q;
	assign ring_nonempty = (count_q != '0);
	assign launch        = (mode == MODE_POLL) && (link_q == LS_IDLE) && ring_nonempty &&
		((in_ch.scan_result == SCAN_FREE) ||
		 ((in_ch.scan_result == SCAN_BUSY) && (busy_inc >= retry_limit_q)));
	assign launch_ok     = launch && (in_ch.radio_status == STAT_OK);
	assign settle_done   = (in_ch.now_ms >= deadline_q);

	assign read_in_range = (32'(in_ch.read_slot) < QUEUE_SLOTS);

	// packet store ram
	assign ram_we    = accept && (mode == MODE_ENQUEUE) && store_ok;
	assign ram_waddr = {tail_q, fill_q};
	assign ram_re    = accept && (mode == MODE_READ_BYTE);
	assign ram_raddr = {SLOT_W'(in_ch.read_slot), in_ch.read_offset};

	lbt_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (in_ch.data_byte),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// link state next-state logic
	always_comb begin
		link_d = link_q;
		unique case (mode)
			MODE_INIT_DONE: link_d = LS_IDLE;
			MODE_RX_IRQ:    link_d = LS_RXED;
			MODE_TX_IRQ:    link_d = LS_SENT;
			MODE_POLL: begin
				unique case (link_q)
					LS_RXED: link_d = LS_IDLE;
					LS_SENT: link_d = LS_SETTLE;
					LS_SETTLE: begin
						if (settle_done) begin
							link_d = LS_IDLE;
						end
					end
					LS_IDLE: begin
						if (launch_ok) begin
							link_d = LS_TX;
						end
					end
					default: link_d = link_q;
				endcase
			end
			default: link_d = link_q;
		endcase
	end

	// ring, counters and result fields
	always_comb begin
		head_d     = head_q;
		tail_d     = tail_q;
		count_d    = count_q;
		fill_d     = fill_q;
		ovf_d      = ovf_q;
		busy_d     = busy_q;
		deadline_d = deadline_q;
		len_we     = 1'b0;
		act_d      = ACT_NONE;
		txs_d      = '0;
		txl_d      = '0;
		unique case (mode)
			MODE_ENQUEUE: begin
				fill_d = fill_inc;
				ovf_d  = ovf_inc;
				if (in_ch.last_byte) begin
					fill_d = '0;
					ovf_d  = 1'b0;
					if (ovf_inc || (count_q >= CNT_W'(QUEUE_SLOTS)) || (fill_inc == '0)) begin
						act_d = ACT_REJECTED;
					end else begin
						len_we  = 1'b1;
						tail_d  = (tail_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : tail_q + 1'b1;
						count_d = count_q + 1'b1;
						act_d   = ACT_QUEUED;
					end
				end
			end
			MODE_POLL: begin
				unique case (link_q)
					LS_RXED: begin
						if (in_ch.radio_status == STAT_OK) begin
							act_d = ACT_RX_DELIVER;
						end else if (in_ch.radio_status == STAT_CRC) begin
							act_d = ACT_CRC_ERR;
						end else begin
							act_d = ACT_READ_ERR;
						end
					end
					LS_SENT: begin
						act_d      = ACT_TX_DONE;
						deadline_d = in_ch.now_ms + TIME_W'(settle_time_q);
					end
					LS_SETTLE: begin
						if (settle_done) begin
							act_d = ACT_RX_RESUMED;
						end
					end
					LS_IDLE: begin
						if (ring_nonempty) begin
							if (launch) begin
								// dequeue head whether or not the send starts
								act_d   = launch_ok ? ACT_TX_START : ACT_TX_FAIL;
								txs_d   = TXSLOT_W'(head_q);
								txl_d   = slot_len_q[head_q];
								head_d  = (head_q == SLOT_W'(QUEUE_SLOTS - 1)) ? '0 : head_q + 1'b1;
								count_d = count_q - 1'b1;
								busy_d  = '0;
							end else if (in_ch.scan_result == SCAN_BUSY) begin
								act_d  = ACT_BUSY;
								busy_d = busy_inc;
							end else begin
								act_d = ACT_SCAN_ERR;
							end
						end
					end
					default: act_d = ACT_NONE;
				endcase
			end
			MODE_READ_BYTE: act_d = ACT_BYTE;
			default: act_d = ACT_NONE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			retry_limit_q <= RETRY_RESET;
			settle_time_q <= SETTLE_RESET;
		end else if (cfg_we) begin
			if (cfg_index == CFG_BUSY_RETRY_LIMIT) begin
				retry_limit_q <= cfg_data[RETRY_W-1:0];
			end
			if (cfg_index == CFG_SETTLE_TIME_MS) begin
				settle_time_q <= cfg_data[SETTLE_W-1:0];
			end
		end
	end

	// control state, updated on the accept edge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q     <= LS_UNINIT;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			fill_q     <= '0;
			ovf_q      <= 1'b0;
			busy_q     <= '0;
			deadline_q <= '0;
		end else if (accept) begin
			link_q     <= link_d;
			head_q     <= head_d;
			tail_q     <= tail_d;
			count_q    <= count_d;
			fill_q     <= fill_d;
			ovf_q      <= ovf_d;
			busy_q     <= busy_d;
			deadline_q <= deadline_d;
		end
	end

	// slot lengths, written when a packet commits
	always_ff @(posedge clk) begin
		if (accept && len_we) begin
			slot_len_q[tail_q] <= fill_inc;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_s1   <= act_d;
			txs_s1   <= txs_d;
			txl_s1   <= txl_d;
			rdsel_s1 <= (mode == MODE_READ_BYTE) && read_in_range;
			busy_s1  <= busy_d;
			depth_s1 <= DEPTH_W'(count_d);
		end
	end

	assign out_ch.valid       = valid_s1;
	assign out_ch.action      = act_s1;
	assign out_ch.tx_slot     = txs_s1;
	assign out_ch.tx_length   = txl_s1;
	assign out_ch.read_data   = rdsel_s1 ? ram_rdata : '0;
	assign out_ch.busy_count  = busy_s1;
	assign out_ch.queue_depth = depth_s1;

endmodule
